FILE: src/uee_pkg.sv
// ----------------------------------------------------------------------------
// uee_pkg
// Shared types, constants and lookup functions for the emoji escape encoder.
// ----------------------------------------------------------------------------
package uee_pkg;

  // Storage sized for the longest lead byte form.
  localparam int SEQ_MAX = 6;
  // Width of a code point that can still hit the emoji table.
  localparam int CP_W    = 17;
  // Decimal digits of the largest table code point.
  localparam int DIG_MAX = 6;
  // Length of the tag opening text.
  localparam int TAG_LEN = 13;

  localparam logic [7:0] CLOSE_CHAR = 8'h5D;
  localparam logic [3:0] ASCII_DIG  = 4'h3;

  // One decoded sequence, handed from the front to the back.
  typedef struct packed {
    logic                      emo_ok;
    logic [CP_W-1:0]           cp;
    logic [2:0]                cnt;
    logic [SEQ_MAX-1:0][7:0]   bytes;
  } entry_t;

  // Characters of the tag opening text, in order.
  function automatic logic [7:0] tag_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h5B;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h51;
      4'd3:    c = 8'h3A;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h6A;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h2C;
      4'd10:   c = 8'h69;
      4'd11:   c = 8'h64;
      4'd12:   c = 8'h3D;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

  function automatic logic in_rng(input logic [CP_W-1:0] cp, input logic [31:0] lo,
                                  input logic [31:0] hi);
    logic [31:0] v;
    v = {{(32-CP_W){1'b0}}, cp};
    return (v >= lo) && (v <= hi);
  endfunction

  // Fixed emoji range table.
  function automatic logic emoji_match(input logic [CP_W-1:0] cp);
    logic h;
    h = 1'b0;
    h |= in_rng(cp,'h23,'h23);       h |= in_rng(cp,'h2A,'h2A);
    h |= in_rng(cp,'h30,'h39);       h |= in_rng(cp,'hA9,'hA9);
    h |= in_rng(cp,'hAE,'hAE);       h |= in_rng(cp,'h203C,'h203C);
    h |= in_rng(cp,'h2049,'h2049);   h |= in_rng(cp,'h2122,'h2122);
    h |= in_rng(cp,'h2139,'h2139);   h |= in_rng(cp,'h2194,'h2195);
    h |= in_rng(cp,'h21A9,'h21AA);   h |= in_rng(cp,'h231A,'h231B);
    h |= in_rng(cp,'h2328,'h2328);   h |= in_rng(cp,'h23CF,'h23CF);
    h |= in_rng(cp,'h23E9,'h23F3);   h |= in_rng(cp,'h23F8,'h23FA);
    h |= in_rng(cp,'h24C2,'h24C2);   h |= in_rng(cp,'h25AA,'h25AB);
    h |= in_rng(cp,'h25B6,'h25B6);   h |= in_rng(cp,'h25C0,'h25C0);
    h |= in_rng(cp,'h25FB,'h25FE);   h |= in_rng(cp,'h2600,'h2604);
    h |= in_rng(cp,'h260E,'h260E);   h |= in_rng(cp,'h2611,'h2611);
    h |= in_rng(cp,'h2614,'h2615);   h |= in_rng(cp,'h2618,'h2618);
    h |= in_rng(cp,'h261D,'h261D);   h |= in_rng(cp,'h2620,'h2620);
    h |= in_rng(cp,'h2622,'h2623);   h |= in_rng(cp,'h2626,'h2626);
    h |= in_rng(cp,'h262A,'h262A);   h |= in_rng(cp,'h262E,'h262F);
    h |= in_rng(cp,'h2638,'h263A);   h |= in_rng(cp,'h2640,'h2640);
    h |= in_rng(cp,'h2642,'h2642);   h |= in_rng(cp,'h2648,'h2653);
    h |= in_rng(cp,'h265F,'h2660);   h |= in_rng(cp,'h2663,'h2663);
    h |= in_rng(cp,'h2665,'h2666);   h |= in_rng(cp,'h2668,'h2668);
    h |= in_rng(cp,'h267B,'h267B);   h |= in_rng(cp,'h267E,'h267F);
    h |= in_rng(cp,'h2692,'h2697);   h |= in_rng(cp,'h2699,'h2699);
    h |= in_rng(cp,'h269B,'h269C);   h |= in_rng(cp,'h26A0,'h26A1);
    h |= in_rng(cp,'h26A7,'h26A7);   h |= in_rng(cp,'h26AA,'h26AB);
    h |= in_rng(cp,'h26B0,'h26B1);   h |= in_rng(cp,'h26BD,'h26BE);
    h |= in_rng(cp,'h26C4,'h26C5);   h |= in_rng(cp,'h26C8,'h26C8);
    h |= in_rng(cp,'h26CE,'h26CF);   h |= in_rng(cp,'h26D1,'h26D1);
    h |= in_rng(cp,'h26D3,'h26D4);   h |= in_rng(cp,'h26E9,'h26EA);
    h |= in_rng(cp,'h26F0,'h26F5);   h |= in_rng(cp,'h26F7,'h26FA);
    h |= in_rng(cp,'h26FD,'h26FD);   h |= in_rng(cp,'h2702,'h2702);
    h |= in_rng(cp,'h2705,'h2705);   h |= in_rng(cp,'h2708,'h270D);
    h |= in_rng(cp,'h270F,'h270F);   h |= in_rng(cp,'h2712,'h2712);
    h |= in_rng(cp,'h2714,'h2714);   h |= in_rng(cp,'h2716,'h2716);
    h |= in_rng(cp,'h271D,'h271D);   h |= in_rng(cp,'h2721,'h2721);
    h |= in_rng(cp,'h2728,'h2728);   h |= in_rng(cp,'h2733,'h2734);
    h |= in_rng(cp,'h2744,'h2744);   h |= in_rng(cp,'h2747,'h2747);
    h |= in_rng(cp,'h274C,'h274C);   h |= in_rng(cp,'h274E,'h274E);
    h |= in_rng(cp,'h2753,'h2755);   h |= in_rng(cp,'h2757,'h2757);
    h |= in_rng(cp,'h2763,'h2764);   h |= in_rng(cp,'h2795,'h2797);
    h |= in_rng(cp,'h27A1,'h27A1);   h |= in_rng(cp,'h27B0,'h27B0);
    h |= in_rng(cp,'h27BF,'h27BF);   h |= in_rng(cp,'h2934,'h2935);
    h |= in_rng(cp,'h2B05,'h2B07);   h |= in_rng(cp,'h2B1B,'h2B1C);
    h |= in_rng(cp,'h2B50,'h2B50);   h |= in_rng(cp,'h2B55,'h2B55);
    h |= in_rng(cp,'h3030,'h3030);   h |= in_rng(cp,'h303D,'h303D);
    h |= in_rng(cp,'h3297,'h3297);   h |= in_rng(cp,'h3299,'h3299);
    h |= in_rng(cp,'h1F004,'h1F004); h |= in_rng(cp,'h1F0CF,'h1F0CF);
    h |= in_rng(cp,'h1F170,'h1F171); h |= in_rng(cp,'h1F17E,'h1F17F);
    h |= in_rng(cp,'h1F18E,'h1F18E); h |= in_rng(cp,'h1F191,'h1F19A);
    h |= in_rng(cp,'h1F1E6,'h1F1FF); h |= in_rng(cp,'h1F201,'h1F202);
    h |= in_rng(cp,'h1F21A,'h1F21A); h |= in_rng(cp,'h1F22F,'h1F22F);
    h |= in_rng(cp,'h1F232,'h1F23A); h |= in_rng(cp,'h1F250,'h1F251);
    h |= in_rng(cp,'h1F300,'h1F321); h |= in_rng(cp,'h1F324,'h1F393);
    h |= in_rng(cp,'h1F396,'h1F397); h |= in_rng(cp,'h1F399,'h1F39B);
    h |= in_rng(cp,'h1F39E,'h1F3F0); h |= in_rng(cp,'h1F3F3,'h1F3F5);
    h |= in_rng(cp,'h1F3F7,'h1F4FD); h |= in_rng(cp,'h1F4FF,'h1F53D);
    h |= in_rng(cp,'h1F549,'h1F54E); h |= in_rng(cp,'h1F550,'h1F567);
    h |= in_rng(cp,'h1F56F,'h1F570); h |= in_rng(cp,'h1F573,'h1F57A);
    h |= in_rng(cp,'h1F587,'h1F587); h |= in_rng(cp,'h1F58A,'h1F58D);
    h |= in_rng(cp,'h1F590,'h1F590); h |= in_rng(cp,'h1F595,'h1F596);
    h |= in_rng(cp,'h1F5A4,'h1F5A5); h |= in_rng(cp,'h1F5A8,'h1F5A8);
    h |= in_rng(cp,'h1F5B1,'h1F5B2); h |= in_rng(cp,'h1F5BC,'h1F5BC);
    h |= in_rng(cp,'h1F5C2,'h1F5C4); h |= in_rng(cp,'h1F5D1,'h1F5D3);
    h |= in_rng(cp,'h1F5DC,'h1F5DE); h |= in_rng(cp,'h1F5E1,'h1F5E1);
    h |= in_rng(cp,'h1F5E3,'h1F5E3); h |= in_rng(cp,'h1F5E8,'h1F5E8);
    h |= in_rng(cp,'h1F5EF,'h1F5EF); h |= in_rng(cp,'h1F5F3,'h1F5F3);
    h |= in_rng(cp,'h1F5FA,'h1F64F); h |= in_rng(cp,'h1F680,'h1F6C5);
    h |= in_rng(cp,'h1F6CB,'h1F6D2); h |= in_rng(cp,'h1F6D5,'h1F6D7);
    h |= in_rng(cp,'h1F6DD,'h1F6E5); h |= in_rng(cp,'h1F6E9,'h1F6E9);
    h |= in_rng(cp,'h1F6EB,'h1F6EC); h |= in_rng(cp,'h1F6F0,'h1F6F0);
    h |= in_rng(cp,'h1F6F3,'h1F6FC); h |= in_rng(cp,'h1F7E0,'h1F7EB);
    h |= in_rng(cp,'h1F7F0,'h1F7F0); h |= in_rng(cp,'h1F90C,'h1F93A);
    h |= in_rng(cp,'h1F93C,'h1F945); h |= in_rng(cp,'h1F947,'h1F9FF);
    h |= in_rng(cp,'h1FA70,'h1FA74); h |= in_rng(cp,'h1FA78,'h1FA7C);
    h |= in_rng(cp,'h1FA80,'h1FA86); h |= in_rng(cp,'h1FA90,'h1FAAC);
    h |= in_rng(cp,'h1FAB0,'h1FABA); h |= in_rng(cp,'h1FAC0,'h1FAC5);
    h |= in_rng(cp,'h1FAD0,'h1FAD9); h |= in_rng(cp,'h1FAE0,'h1FAE7);
    h |= in_rng(cp,'h1FAF0,'h1FAF6);
    return h;
  endfunction

endpackage

FILE: src/utf8_emoji_escape_encoder.sv
// ----------------------------------------------------------------------------
// utf8_emoji_escape_encoder
// UTF-8 byte stream in, text out with emoji replaced by decimal id tags.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_byte, in_string_end
//   out_    | output    | out_valid/out_stall| out_byte, out_run_last
//
// One input byte is taken per cycle while the sequence queue has room.
// The back emits one output byte per cycle unless the output stalls; a
// passthrough sequence of n bytes gives n bytes, an emoji tag 16 to 20 bytes.
// Reset is synchronous and clears the tracker, queue and sequencer.
// Output stall backs up the four-entry queue, which then stalls the input.
module utf8_emoji_escape_encoder #(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic            acc, push, pop, full, head_valid;
  uee_pkg::entry_t push_entry, head;

  // A transaction is accepted whenever the queue has room.
  assign in_stall = full;
  assign acc      = in_valid && !full;

  uee_front #(.MAX_SEQ_BYTES(MAX_SEQ_BYTES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .push          (push),
    .push_entry    (push_entry)
  );

  uee_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  uee_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

FILE: src/uee_front.sv
// ----------------------------------------------------------------------------
// uee_front
// Groups incoming bytes into UTF-8 sequences and decodes each finished one.
// ----------------------------------------------------------------------------
module uee_front #(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      in_byte,
  input  logic            in_string_end,
  output logic            push,
  output uee_pkg::entry_t push_entry
);

  logic [2:0] exp_r, exp_nxt;
  logic [2:0] held_r, held_nxt;
  logic       stop_r, stop_nxt;
  logic [uee_pkg::SEQ_MAX-1:0][7:0] seq_r, seq_nxt;

  logic       open_new, cont;
  logic [2:0] pos, new_held, exp_eff, lead_len;
  logic [31:0] v;
  logic        dec_ok;

  // Sequence length from the lead byte, capped at the configured maximum.
  always_comb begin
    if (in_byte >= 8'hFC)      lead_len = 3'd6;
    else if (in_byte >= 8'hF8) lead_len = 3'd5;
    else if (in_byte >= 8'hF0) lead_len = 3'd4;
    else if (in_byte >= 8'hE0) lead_len = 3'd3;
    else if (in_byte >= 8'hC0) lead_len = 3'd2;
    else                       lead_len = 3'd1;
    if (lead_len > 3'(MAX_SEQ_BYTES)) lead_len = 3'(MAX_SEQ_BYTES);
  end

  // Place the new byte and work out whether the sequence closes.
  always_comb begin
    open_new = !stop_r && (exp_r == 3'd0) && (in_byte != 8'h00);
    cont     = !stop_r && (exp_r != 3'd0);
    pos      = open_new ? 3'd0 : held_r;
    new_held = pos + 3'd1;
    exp_eff  = open_new ? lead_len : exp_r;
    seq_nxt  = seq_r;
    if (acc && (open_new || cont)) begin
      seq_nxt[pos] = in_byte;
    end
    push = acc && (open_new || cont) && ((new_held >= exp_eff) || in_string_end);
  end

  // Lenient decode of the held bytes.
  always_comb begin
    case (new_held)
      3'd1:    v = {24'd0, seq_nxt[0]};
      3'd2:    v = {27'd0, seq_nxt[0][4:0]};
      3'd3:    v = {28'd0, seq_nxt[0][3:0]};
      3'd4:    v = {29'd0, seq_nxt[0][2:0]};
      default: v = {30'd0, seq_nxt[0][1:0]};
    endcase
    for (int i = 1; i < uee_pkg::SEQ_MAX; i++) begin
      if (3'(i) < new_held) v = {v[25:0], seq_nxt[i][5:0]};
    end
    dec_ok = !((new_held == 3'd1) && seq_nxt[0][7]);
    push_entry.emo_ok = dec_ok && (v[31:uee_pkg::CP_W] == '0);
    push_entry.cp     = v[uee_pkg::CP_W-1:0];
    push_entry.cnt    = new_held;
    push_entry.bytes  = seq_nxt;
  end

  // Next state of the sequence tracker.
  always_comb begin
    exp_nxt  = exp_r;
    held_nxt = held_r;
    stop_nxt = stop_r;
    if (acc) begin
      if (open_new || cont) begin
        exp_nxt  = exp_eff;
        held_nxt = new_held;
      end else if (!stop_r) begin
        stop_nxt = 1'b1;
      end
      if (push) begin
        exp_nxt  = 3'd0;
        held_nxt = 3'd0;
      end
      if (in_string_end) begin
        exp_nxt  = 3'd0;
        held_nxt = 3'd0;
        stop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    if (!rst_n) begin
      exp_r  <= 3'd0;
      held_r <= 3'd0;
      stop_r <= 1'b0;
    end else begin
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

FILE: src/uee_queue.sv
// ----------------------------------------------------------------------------
// uee_queue
// Four-entry queue of decoded sequences between the front and the back.
// ----------------------------------------------------------------------------
module uee_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uee_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output uee_pkg::entry_t head
);

  uee_pkg::entry_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 3'd4);
  assign head_valid = (cnt_r != 3'd0);
  assign head       = mem_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/uee_back.sv
// ----------------------------------------------------------------------------
// uee_back
// Emits raw bytes or escape tag of a sequence, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module uee_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  uee_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PASS  = 5'b00010,
    S_HEAD  = 5'b00100,
    S_DIG   = 5'b01000,
    S_CLOSE = 5'b10000
  } bst_t;

  bst_t st_r, st_nxt;
  logic [3:0] bi_r, bi_nxt;
  logic [2:0] di_r, di_nxt;
  logic [2:0] cnt_r;
  logic [uee_pkg::SEQ_MAX-1:0][7:0] bytes_r;

  logic                       dv_busy_r, dv_busy_nxt;
  logic [uee_pkg::CP_W-1:0]   dv_x_r, dv_x_nxt;
  logic [2:0]                 nd_r, nd_nxt;
  logic [3:0]                 dig_r [uee_pkg::DIG_MAX];
  logic [36:0]                prod;
  logic [uee_pkg::CP_W-1:0]   quo, rem;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       can_emit, emit, e_last, start, load;
  logic [7:0] e_byte;

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;
  assign can_emit     = !out_valid_r || !out_stall;

  // Divide by ten through a reciprocal multiply, one digit a cycle.
  always_comb begin
    prod = 37'(dv_x_r) * 37'(20'hCCCCD);
    quo  = {3'd0, prod[36:23]};
    rem  = dv_x_r - uee_pkg::CP_W'(quo * 17'd10);
  end

  // Sequencer for passthrough bytes and tag text.
  always_comb begin
    st_nxt = st_r;
    bi_nxt = bi_r;
    di_nxt = di_r;
    pop    = 1'b0;
    emit   = 1'b0;
    e_last = 1'b0;
    e_byte = 8'h00;
    start  = 1'b0;
    load   = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (head_valid && can_emit) begin
          pop  = 1'b1;
          load = 1'b1;
          emit = 1'b1;
          if (head.emo_ok && uee_pkg::emoji_match(head.cp)) begin
            start  = 1'b1;
            e_byte = uee_pkg::tag_byte(4'd0);
            bi_nxt = 4'd1;
            st_nxt = S_HEAD;
          end else begin
            e_byte = head.bytes[0];
            e_last = (head.cnt == 3'd1);
            bi_nxt = 4'd1;
            if (head.cnt != 3'd1) st_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = bytes_r[bi_r[2:0]];
          e_last = (bi_r[2:0] == cnt_r - 3'd1);
          bi_nxt = bi_r + 4'd1;
          if (e_last) st_nxt = S_IDLE;
        end
      end
      S_HEAD: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = uee_pkg::tag_byte(bi_r);
          bi_nxt = bi_r + 4'd1;
          if (bi_r == 4'(uee_pkg::TAG_LEN - 1)) begin
            st_nxt = S_DIG;
            di_nxt = nd_r - 3'd1;
          end
        end
      end
      S_DIG: begin
        if (can_emit && !dv_busy_r) begin
          emit   = 1'b1;
          e_byte = {uee_pkg::ASCII_DIG, dig_r[di_r]};
          di_nxt = di_r - 3'd1;
          if (di_r == 3'd0) st_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = uee_pkg::CLOSE_CHAR;
          e_last = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Digit unit next state; it finishes well within the tag opening text.
  always_comb begin
    dv_busy_nxt = dv_busy_r;
    dv_x_nxt    = dv_x_r;
    nd_nxt      = nd_r;
    if (start) begin
      dv_busy_nxt = 1'b1;
      dv_x_nxt    = head.cp;
      nd_nxt      = 3'd0;
    end else if (dv_busy_r) begin
      dv_x_nxt = quo;
      nd_nxt   = nd_r + 3'd1;
      if (quo == '0) dv_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= head.bytes;
      cnt_r   <= head.cnt;
    end
    if (dv_busy_r && !start) begin
      dig_r[nd_r] <= rem[3:0];
    end
    if (emit) begin
      out_byte_r <= e_byte;
      out_last_r <= e_last;
    end
    dv_x_r <= dv_x_nxt;
    nd_r   <= nd_nxt;
    bi_r   <= bi_nxt;
    di_r   <= di_nxt;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      dv_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      dv_busy_r <= dv_busy_nxt;
      if (can_emit) out_valid_r <= emit;
    end
  end

endmodule

FILE: tb/sv/utf8_emoji_escape_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_emoji_escape_encoder_tb
// Drives byte strings through the encoder and compares every output byte
// against an in-bench predictor of the UTF-8 grouping and emoji tagging.
// ----------------------------------------------------------------------------
module utf8_emoji_escape_encoder_tb;

  localparam int SEQ_LIMIT = 6;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_string_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_run_last;

  // Expected output bytes, with the last-of-run flag in bit 8.
  logic [8:0] text_queue[$];

  // Predictor state.
  logic [7:0] seq_buf[SEQ_LIMIT];
  int         seq_len;
  int         seq_held;
  bit         nul_stop;

  int error_count;
  int bytes_sent;
  int bytes_checked;
  int emoji_seen;
  int src_idle_pct;
  int dst_idle_pct;
  bit hold_off;

  utf8_emoji_escape_encoder #(.MAX_SEQ_BYTES(SEQ_LIMIT)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Emoji range table, held as pairs of bounds.
  localparam int NRANGE = 153;
  localparam logic [16:0] RANGE_TAB[NRANGE][2] = '{
    '{'h23,'h23},'{'h2A,'h2A},'{'h30,'h39},'{'hA9,'hA9},'{'hAE,'hAE},
    '{'h203C,'h203C},'{'h2049,'h2049},'{'h2122,'h2122},'{'h2139,'h2139},
    '{'h2194,'h2195},'{'h21A9,'h21AA},'{'h231A,'h231B},'{'h2328,'h2328},
    '{'h23CF,'h23CF},'{'h23E9,'h23F3},'{'h23F8,'h23FA},'{'h24C2,'h24C2},
    '{'h25AA,'h25AB},'{'h25B6,'h25B6},'{'h25C0,'h25C0},'{'h25FB,'h25FE},
    '{'h2600,'h2604},'{'h260E,'h260E},'{'h2611,'h2611},'{'h2614,'h2615},
    '{'h2618,'h2618},'{'h261D,'h261D},'{'h2620,'h2620},'{'h2622,'h2623},
    '{'h2626,'h2626},'{'h262A,'h262A},'{'h262E,'h262F},'{'h2638,'h263A},
    '{'h2640,'h2640},'{'h2642,'h2642},'{'h2648,'h2653},'{'h265F,'h2660},
    '{'h2663,'h2663},'{'h2665,'h2666},'{'h2668,'h2668},'{'h267B,'h267B},
    '{'h267E,'h267F},'{'h2692,'h2697},'{'h2699,'h2699},'{'h269B,'h269C},
    '{'h26A0,'h26A1},'{'h26A7,'h26A7},'{'h26AA,'h26AB},'{'h26B0,'h26B1},
    '{'h26BD,'h26BE},'{'h26C4,'h26C5},'{'h26C8,'h26C8},'{'h26CE,'h26CF},
    '{'h26D1,'h26D1},'{'h26D3,'h26D4},'{'h26E9,'h26EA},'{'h26F0,'h26F5},
    '{'h26F7,'h26FA},'{'h26FD,'h26FD},'{'h2702,'h2702},'{'h2705,'h2705},
    '{'h2708,'h270D},'{'h270F,'h270F},'{'h2712,'h2712},'{'h2714,'h2714},
    '{'h2716,'h2716},'{'h271D,'h271D},'{'h2721,'h2721},'{'h2728,'h2728},
    '{'h2733,'h2734},'{'h2744,'h2744},'{'h2747,'h2747},'{'h274C,'h274C},
    '{'h274E,'h274E},'{'h2753,'h2755},'{'h2757,'h2757},'{'h2763,'h2764},
    '{'h2795,'h2797},'{'h27A1,'h27A1},'{'h27B0,'h27B0},'{'h27BF,'h27BF},
    '{'h2934,'h2935},'{'h2B05,'h2B07},'{'h2B1B,'h2B1C},'{'h2B50,'h2B50},
    '{'h2B55,'h2B55},'{'h3030,'h3030},'{'h303D,'h303D},'{'h3297,'h3297},
    '{'h3299,'h3299},
    '{'h1F004,'h1F004},'{'h1F0CF,'h1F0CF},'{'h1F170,'h1F171},'{'h1F17E,'h1F17F},
    '{'h1F18E,'h1F18E},'{'h1F191,'h1F19A},'{'h1F1E6,'h1F1FF},'{'h1F201,'h1F202},
    '{'h1F21A,'h1F21A},'{'h1F22F,'h1F22F},'{'h1F232,'h1F23A},'{'h1F250,'h1F251},
    '{'h1F300,'h1F321},'{'h1F324,'h1F393},'{'h1F396,'h1F397},'{'h1F399,'h1F39B},
    '{'h1F39E,'h1F3F0},'{'h1F3F3,'h1F3F5},'{'h1F3F7,'h1F4FD},'{'h1F4FF,'h1F53D},
    '{'h1F549,'h1F54E},'{'h1F550,'h1F567},'{'h1F56F,'h1F570},'{'h1F573,'h1F57A},
    '{'h1F587,'h1F587},'{'h1F58A,'h1F58D},'{'h1F590,'h1F590},'{'h1F595,'h1F596},
    '{'h1F5A4,'h1F5A5},'{'h1F5A8,'h1F5A8},'{'h1F5B1,'h1F5B2},'{'h1F5BC,'h1F5BC},
    '{'h1F5C2,'h1F5C4},'{'h1F5D1,'h1F5D3},'{'h1F5DC,'h1F5DE},'{'h1F5E1,'h1F5E1},
    '{'h1F5E3,'h1F5E3},'{'h1F5E8,'h1F5E8},'{'h1F5EF,'h1F5EF},'{'h1F5F3,'h1F5F3},
    '{'h1F5FA,'h1F64F},'{'h1F680,'h1F6C5},'{'h1F6CB,'h1F6D2},'{'h1F6D5,'h1F6D7},
    '{'h1F6DD,'h1F6E5},'{'h1F6E9,'h1F6E9},'{'h1F6EB,'h1F6EC},'{'h1F6F0,'h1F6F0},
    '{'h1F6F3,'h1F6FC},'{'h1F7E0,'h1F7EB},'{'h1F7F0,'h1F7F0},'{'h1F90C,'h1F93A},
    '{'h1F93C,'h1F945},'{'h1F947,'h1F9FF},'{'h1FA70,'h1FA74},'{'h1FA78,'h1FA7C},
    '{'h1FA80,'h1FA86},'{'h1FA90,'h1FAAC},'{'h1FAB0,'h1FABA},'{'h1FAC0,'h1FAC5},
    '{'h1FAD0,'h1FAD9},'{'h1FAE0,'h1FAE7},'{'h1FAF0,'h1FAF6}
  };

  localparam string TAG_TEXT = "[CQ:emoji,id=";

  function automatic bit emoji_hit(input logic [31:0] cp);
    if (cp > 32'h1FFFF) return 1'b0;
    for (int i = 0; i < NRANGE; i++)
      if (cp >= RANGE_TAB[i][0] && cp <= RANGE_TAB[i][1]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int lead_count(input logic [7:0] b);
    if (b >= 8'hFC) return 6;
    if (b >= 8'hF8) return 5;
    if (b >= 8'hF0) return 4;
    if (b >= 8'hE0) return 3;
    if (b >= 8'hC0) return 2;
    return 1;
  endfunction

  // Decode the held bytes and queue either the tag or the raw bytes.
  task automatic emit_sequence();
    logic [31:0] cp;
    bit          ok;
    string       digits;
    ok = 1'b1;
    cp = 0;
    case (seq_held)
      1: begin
        ok = (seq_buf[0] < 8'h80);
        cp = seq_buf[0];
      end
      2: cp = seq_buf[0] & 8'h1F;
      3: cp = seq_buf[0] & 8'h0F;
      4: cp = seq_buf[0] & 8'h07;
      default: cp = seq_buf[0] & 8'h03;
    endcase
    for (int i = 1; i < seq_held; i++) cp = (cp << 6) | (seq_buf[i] & 8'h3F);
    if (ok && emoji_hit(cp)) begin
      emoji_seen++;
      digits = $sformatf("%0d", cp);
      for (int i = 0; i < TAG_TEXT.len(); i++) text_queue.push_back({1'b0, TAG_TEXT[i]});
      for (int i = 0; i < digits.len(); i++) text_queue.push_back({1'b0, digits[i]});
      text_queue.push_back({1'b0, 8'h5D});
    end else begin
      for (int i = 0; i < seq_held; i++) text_queue.push_back({1'b0, seq_buf[i]});
    end
    seq_len  = 0;
    seq_held = 0;
  endtask

  // Predict the output bytes caused by one input transaction.
  task automatic predict_text(input logic [7:0] b, input bit last);
    int before_cnt;
    before_cnt = text_queue.size();
    if (nul_stop) begin
    end else if (seq_len == 0) begin
      if (b == 8'h00) begin
        nul_stop = 1'b1;
      end else begin
        seq_buf[0] = b;
        seq_held   = 1;
        seq_len    = lead_count(b);
        if (seq_held >= seq_len || last) emit_sequence();
      end
    end else begin
      if (seq_held < SEQ_LIMIT) begin
        seq_buf[seq_held] = b;
        seq_held++;
      end
      if (seq_held >= seq_len || last) emit_sequence();
    end
    if (last) begin
      seq_len  = 0;
      seq_held = 0;
      nul_stop = 1'b0;
    end
    if (text_queue.size() > before_cnt) text_queue[$][8] = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Send one byte; prediction happens at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_string_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text(b, last);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  // Receiver stall control.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < dst_idle_pct);
    end
  end

  // Output checker.
  always @(posedge clk) begin
    logic [8:0] exp_item;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (text_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte));
      end else begin
        exp_item = text_queue.pop_front();
        if (out_byte !== exp_item[7:0])
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte,
                                    exp_item[7:0]));
        if (out_run_last !== exp_item[8])
          report_mismatch($sformatf("out_run_last %0b, expected %0b", out_run_last,
                                    exp_item[8]));
      end
    end
  end

  // Directed: ASCII, digits, sequences of every length, NUL and truncation.
  task automatic test_directed();
    send_string('{8'h41, 8'h23, 8'h2A, 8'h30, 8'h39, 8'h7F});
    send_string('{8'hC2, 8'hA9, 8'hC2, 8'hAE, 8'hC3, 8'hBF});
    send_string('{8'hE2, 8'h80, 8'hBC, 8'hE4, 8'hB8, 8'h80});
    send_string('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF0, 8'h9F, 8'hAB, 8'hB6});
    send_string('{8'hF8, 8'h80, 8'h80, 8'h80, 8'hA3, 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80});
    send_string('{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'hA3, 8'hFF, 8'hBF, 8'hBF,
                  8'hBF, 8'hBF, 8'hBF});
    // Stray continuation bytes, NUL in a sequence and at a lead position.
    send_string('{8'h80, 8'hBF, 8'hC0, 8'h00, 8'h31, 8'h00, 8'h32, 8'h33});
    send_string('{8'hF0, 8'h9F});
    send_string('{8'hFF});
    send_string('{8'h00});
  endtask

  // Random strings, mostly well-formed UTF-8 with emoji mixed in.
  task automatic test_random(input int n_bytes);
    logic [7:0] s[$];
    int         kind;
    logic [31:0] cp;
    while (n_bytes > 0) begin
      s = {};
      repeat ($urandom_range(5, 1)) begin
        kind = $urandom_range(9);
        case (kind)
          0, 1: s.push_back(8'($urandom_range(8'h7F, 8'h01)));
          2: s.push_back(8'($urandom_range(8'h39, 8'h30)));
          3: begin
            cp = $urandom_range(32'h7FF, 32'h80);
            s.push_back(8'hC0 | {3'd0, cp[10:6]});
            s.push_back(8'h80 | {2'd0, cp[5:0]});
          end
          4: begin
            cp = $urandom_range(32'h27BF, 32'h2000);
            s.push_back(8'hE0 | {4'd0, cp[15:12]});
            s.push_back(8'h80 | {2'd0, cp[11:6]});
            s.push_back(8'h80 | {2'd0, cp[5:0]});
          end
          5, 6: begin
            cp = $urandom_range(32'h1FAFF, 32'h1F000);
            s.push_back(8'hF0 | {5'd0, cp[20:18]});
            s.push_back(8'h80 | {2'd0, cp[17:12]});
            s.push_back(8'h80 | {2'd0, cp[11:6]});
            s.push_back(8'h80 | {2'd0, cp[5:0]});
          end
          7: repeat ($urandom_range(6, 5)) s.push_back(8'($urandom_range(255, 8'hF8)));
          8: s.push_back(8'h00);
          default: s.push_back(8'($urandom_range(255)));
        endcase
      end
      n_bytes -= s.size();
      send_string(s);
    end
  endtask

  // Receiver holds off while the sender keeps offering bytes.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        int held;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      send_string('{8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h41});
    join
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    while (text_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte       <= 8'h00;
    in_string_end <= 1'b0;
    hold_off      = 1'b0;
    src_idle_pct  = 10;
    dst_idle_pct  = 73;
    error_count   = 0;
    bytes_sent    = 0;
    bytes_checked = 0;
    emoji_seen    = 0;
    seq_len       = 0;
    seq_held      = 0;
    nul_stop      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(15);
    src_idle_pct = 73;
    dst_idle_pct = 10;
    test_random(15);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_backpressure();
    test_random(10);
    drain_queue();

    $display("Sent %0d bytes, checked %0d output bytes, %0d emoji tags.",
             bytes_sent, bytes_checked, emoji_seen);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("Timeout reached.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
